@@ hw/rtl/efhps_pkg.sv @@
// Shared types and constants for the ECMP flow-hash path selector.
// Holds the payload structs, the hash constants and the protocol codes.
// No dependencies.
`default_nettype none

package efhps_pkg;

	// Number of next-hop port inputs on each header
	localparam int HOP_INPUTS = 4;

	// MurmurHash3 x86_32 constants
	localparam logic [31:0] MUR_C1    = 32'hcc9e2d51;
	localparam logic [31:0] MUR_C2    = 32'h1b873593;
	localparam logic [31:0] MUR_N     = 32'he6546b64;
	localparam logic [31:0] MUR_F1    = 32'h85ebca6b;
	localparam logic [31:0] MUR_F2    = 32'hc2b2ae35;
	localparam logic [31:0] KEY_BYTES = 32'd12;

	// Supported protocol codes
	localparam logic [7:0] PROTO_TCP  = 8'h06;
	localparam logic [7:0] PROTO_UDP  = 8'h11;
	localparam logic [7:0] PROTO_ACK  = 8'hFC;
	localparam logic [7:0] PROTO_NACK = 8'hFD;

	typedef struct packed {
		logic [31:0] source_address;
		logic [31:0] dest_address;
		logic [7:0]  protocol;
		logic [15:0] source_port;
		logic [15:0] dest_port;
		logic [2:0]  path_count;
		logic [7:0]  hop_port_0;
		logic [7:0]  hop_port_1;
		logic [7:0]  hop_port_2;
		logic [7:0]  hop_port_3;
	} flow_in_t;

	typedef struct packed {
		logic [7:0]  chosen_port;
		logic [1:0]  chosen_index;
		logic [31:0] flow_hash;
		logic        unsupported;
	} flow_out_t;

	// Per-item fields that ride alongside the hash through the pipeline
	typedef struct packed {
		logic                             supported;
		logic [2:0]                       path_cnt;
		logic [HOP_INPUTS-1:0][7:0]       hop_port;
	} flow_side_t;

	// The three hashed key words
	typedef logic [2:0][31:0] key_words_t;

endpackage

`default_nettype wire

@@ hw/rtl/efhps_key_mix.sv @@
// Key scrambling stages s1 and s2: k = rotl(k * C1, 15) * C2 for each word.
// Depends on efhps_pkg for constants and the sideband struct.
`default_nettype none

module efhps_key_mix (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        advance,
	input  wire                        valid,
	input  efhps_pkg::key_words_t      words,
	input  efhps_pkg::flow_side_t      side,
	output logic                       valid_s2,
	output efhps_pkg::key_words_t      keys_s2,
	output efhps_pkg::flow_side_t      side_s2
);

	logic                  valid_s1;
	efhps_pkg::key_words_t prod_s1;
	efhps_pkg::flow_side_t side_s1;
	efhps_pkg::key_words_t prod_c2;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= valid;
			valid_s2 <= valid_s1;
		end
	end

	// Rotate the first product and multiply by the second constant
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			prod_c2[i] = {prod_s1[i][16:0], prod_s1[i][31:17]} * efhps_pkg::MUR_C2;
		end
	end

	// Stage registers: first multiply, then second multiply
	always_ff @(posedge clk) begin
		if (advance) begin
			for (int i = 0; i < 3; i++) begin
				prod_s1[i] <= words[i] * efhps_pkg::MUR_C1;
			end
			side_s1 <= side;
			keys_s2 <= prod_c2;
			side_s2 <= side_s1;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/efhps_hash_fin.sv @@
// Hash state stages s3..s6: the three mixing rounds and the finalizer multiplies.
// Depends on efhps_pkg for constants and types.
`default_nettype none

module efhps_hash_fin (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        advance,
	input  wire  [31:0]                seed,
	input  wire                        valid,
	input  efhps_pkg::key_words_t      keys,
	input  efhps_pkg::flow_side_t      side,
	output logic                       valid_s6,
	output logic [31:0]                hash_s6,
	output efhps_pkg::flow_side_t      side_s6
);

	// One mixing round: h ^= k, rotl 13, h * 5 + N
	function automatic logic [31:0] mur_round(input logic [31:0] h, input logic [31:0] k);
		logic [31:0] t;
		t = h ^ k;
		t = {t[18:0], t[31:19]};
		return {t[29:0], 2'b00} + t + efhps_pkg::MUR_N;
	endfunction

	logic                  valid_s3, valid_s4, valid_s5;
	logic [31:0]           h_s3, h_s4, h_s5;
	logic [31:0]           k2_s3;
	efhps_pkg::flow_side_t side_s3, side_s4, side_s5;
	logic [31:0]           round3, fold16, fold13;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (advance) begin
			valid_s3 <= valid;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	// Third round, length fold and first shift-xor
	always_comb begin
		round3 = mur_round(h_s3, k2_s3) ^ efhps_pkg::KEY_BYTES;
		fold16 = round3 ^ {16'd0, round3[31:16]};
		fold13 = h_s5 ^ {13'd0, h_s5[31:13]};
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			h_s3    <= mur_round(mur_round(seed, keys[0]), keys[1]);
			k2_s3   <= keys[2];
			side_s3 <= side;
			h_s4    <= fold16;
			side_s4 <= side_s3;
			h_s5    <= h_s4 * efhps_pkg::MUR_F1;
			side_s5 <= side_s4;
			hash_s6 <= fold13 * efhps_pkg::MUR_F2;
			side_s6 <= side_s5;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/efhps_path_sel.sv @@
// Final hash fold and next-hop selection, stages s7 and s8 (output register).
// Depends on efhps_pkg for the sideband and result structs.
`default_nettype none

module efhps_path_sel (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        advance,
	input  wire                        valid,
	input  wire  [31:0]                hash_pre,
	input  efhps_pkg::flow_side_t      side,
	output logic                       valid_s8,
	output efhps_pkg::flow_out_t       result_s8
);

	logic                  valid_s7;
	logic [31:0]           hash_s7;
	logic [3:0][3:0]       grp_s7;
	efhps_pkg::flow_side_t side_s7;
	logic [31:0]           hash_fin;
	logic [3:0][3:0]       grp_sum;
	logic [5:0]            digit_total;
	logic [3:0]            digit_fold;
	logic [1:0]            mod3;
	logic [1:0]            index;
	efhps_pkg::flow_out_t  result;

	// Last shift-xor, then partial base-4 digit sums for the mod-3 reduction
	always_comb begin
		hash_fin = hash_pre ^ {16'd0, hash_pre[31:16]};
		for (int g = 0; g < 4; g++) begin
			grp_sum[g] = 4'(hash_fin[8*g +: 2]) + 4'(hash_fin[8*g+2 +: 2])
				+ 4'(hash_fin[8*g+4 +: 2]) + 4'(hash_fin[8*g+6 +: 2]);
		end
	end

	// Reduce modulo path count; 4 is 1 mod 3, so digit sums keep the residue
	always_comb begin
		digit_total = 6'(grp_s7[0]) + 6'(grp_s7[1]) + 6'(grp_s7[2]) + 6'(grp_s7[3]);
		digit_fold  = 4'(digit_total[5:4]) + 4'(digit_total[3:2]) + 4'(digit_total[1:0]);
		if (digit_fold >= 4'd6) begin
			mod3 = 2'(digit_fold - 4'd6);
		end else if (digit_fold >= 4'd3) begin
			mod3 = 2'(digit_fold - 4'd3);
		end else begin
			mod3 = digit_fold[1:0];
		end
		unique case (side_s7.path_cnt)
			3'd2:    index = {1'b0, hash_s7[0]};
			3'd3:    index = mod3;
			3'd4:    index = hash_s7[1:0];
			default: index = 2'd0;
		endcase
		result.flow_hash   = hash_s7;
		result.unsupported = ~side_s7.supported;
		if (side_s7.supported) begin
			result.chosen_index = index;
			result.chosen_port  = side_s7.hop_port[index];
		end else begin
			result.chosen_index = 2'd0;
			result.chosen_port  = 8'd0;
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
		end else if (advance) begin
			valid_s7 <= valid;
			valid_s8 <= valid_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			hash_s7   <= hash_fin;
			grp_s7    <= grp_sum;
			side_s7   <= side;
			result_s8 <= result;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/ecmp_flow_hash_path_select.sv @@
// Top level of the ECMP flow-hash path selector: handshake, seed register,
// sideband decode. Instantiates efhps_key_mix, efhps_hash_fin, efhps_path_sel.
//
//   Channel   Signals                        Moves
//   in        in_valid / in_ready / in_data  one packet header (flow_in_t)
//   out       out_valid / out_ready / out_data  one selection (flow_out_t)
//   cfg       cfg_valid / cfg_ready / cfg_data  hash seed write
//
// One header per cycle while the output is not held; each result passes through
// the eight register stages (s1 to s8) of the hash and select pipeline.
// Reset clears all valid bits and sets the seed to zero; cfg_ready is always high.
// When the output holds an untaken result, every stage holds; nothing is dropped.
`default_nettype none

module ecmp_flow_hash_path_select #(
	parameter int MAX_PATHS = 4
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_ready,
	input  efhps_pkg::flow_in_t    in_data,
	output logic                   out_valid,
	input  wire                    out_ready,
	output efhps_pkg::flow_out_t   out_data,
	input  wire                    cfg_valid,
	output logic                   cfg_ready,
	input  wire  [31:0]            cfg_data
);

	// Effective path limit: the parameter, capped by the hop inputs
	localparam logic [2:0] PathLimit =
		3'((MAX_PATHS < efhps_pkg::HOP_INPUTS) ? MAX_PATHS : efhps_pkg::HOP_INPUTS);

	logic [31:0]           hash_seed_q;
	logic                  advance;
	logic                  in_xfer;
	efhps_pkg::key_words_t words;
	efhps_pkg::flow_side_t side_in;
	logic                  valid_s2, valid_s6;
	efhps_pkg::key_words_t keys_s2;
	efhps_pkg::flow_side_t side_s2, side_s6;
	logic [31:0]           hash_s6;

	// Hold every stage while a result waits at the output
	assign advance   = ~out_valid | out_ready;
	assign in_ready  = advance;
	assign in_xfer   = in_valid & in_ready;
	assign cfg_ready = 1'b1;

	// Seed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_seed_q <= 32'd0;
		end else if (cfg_valid) begin
			hash_seed_q <= cfg_data;
		end
	end

	// Build key words, clamp path count, classify protocol
	always_comb begin
		words[0] = in_data.source_address;
		words[1] = in_data.dest_address;
		words[2] = {in_data.dest_port, in_data.source_port};
		side_in.supported = (in_data.protocol == efhps_pkg::PROTO_TCP)
			|| (in_data.protocol == efhps_pkg::PROTO_UDP)
			|| (in_data.protocol == efhps_pkg::PROTO_ACK)
			|| (in_data.protocol == efhps_pkg::PROTO_NACK);
		if (in_data.path_count == 3'd0) begin
			side_in.path_cnt = 3'd1;
		end else if (in_data.path_count > PathLimit) begin
			side_in.path_cnt = PathLimit;
		end else begin
			side_in.path_cnt = in_data.path_count;
		end
		side_in.hop_port[0] = in_data.hop_port_0;
		side_in.hop_port[1] = in_data.hop_port_1;
		side_in.hop_port[2] = in_data.hop_port_2;
		side_in.hop_port[3] = in_data.hop_port_3;
	end

	efhps_key_mix u_key_mix (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.valid    (in_xfer),
		.words    (words),
		.side     (side_in),
		.valid_s2 (valid_s2),
		.keys_s2  (keys_s2),
		.side_s2  (side_s2)
	);

	efhps_hash_fin u_hash_fin (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.seed     (hash_seed_q),
		.valid    (valid_s2),
		.keys     (keys_s2),
		.side     (side_s2),
		.valid_s6 (valid_s6),
		.hash_s6  (hash_s6),
		.side_s6  (side_s6)
	);

	efhps_path_sel u_path_sel (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.valid     (valid_s6),
		.hash_pre  (hash_s6),
		.side      (side_s6),
		.valid_s8  (out_valid),
		.result_s8 (out_data)
	);

endmodule

`default_nettype wire

@@ bench/ecmp_flow_hash_path_select_tb.sv @@
// Self-checking bench for ecmp_flow_hash_path_select: murmur flow hash and next-hop pick.
// Depends on efhps_pkg for the header and selection structs, hash constants and protocol codes.
// A scoreboard class predicts each selection; plain tasks drive headers and seed writes, an initial block drives ready.
`timescale 1ns / 1ps

module ecmp_flow_hash_path_select_tb;

	localparam int MAX_PATHS    = 4;
	localparam int PHASES       = 6;
	localparam int PHASE_ITEMS  = 322;
	localparam int DRAIN_CYCLES = 16;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int REPORT_MAX   = 10;

	// Predict selections and check them in transfer order
	class path_select_board;
		bit [31:0]            seed;
		efhps_pkg::flow_out_t expected_q[$];
		int                   mismatches;

		function bit [31:0] rotl(bit [31:0] x, int r);
			return (x << r) | (x >> (32 - r));
		endfunction

		function bit [31:0] mix_word(bit [31:0] acc, bit [31:0] k);
			k = k * efhps_pkg::MUR_C1;
			k = rotl(k, 15);
			k = k * efhps_pkg::MUR_C2;
			acc = acc ^ k;
			acc = rotl(acc, 13);
			return acc * 5 + efhps_pkg::MUR_N;
		endfunction

		function bit [31:0] murmur_key(bit [31:0] w0, bit [31:0] w1, bit [31:0] w2);
			bit [31:0] acc;
			acc = seed;
			acc = mix_word(acc, w0);
			acc = mix_word(acc, w1);
			acc = mix_word(acc, w2);
			acc = acc ^ efhps_pkg::KEY_BYTES;
			acc = acc ^ (acc >> 16);
			acc = acc * efhps_pkg::MUR_F1;
			acc = acc ^ (acc >> 13);
			acc = acc * efhps_pkg::MUR_F2;
			acc = acc ^ (acc >> 16);
			return acc;
		endfunction

		function efhps_pkg::flow_out_t select_path(efhps_pkg::flow_in_t h);
			efhps_pkg::flow_out_t r;
			bit [31:0]            hash;
			int unsigned          ways;
			bit [7:0]             hops [4];
			hops = '{h.hop_port_0, h.hop_port_1, h.hop_port_2, h.hop_port_3};
			hash = murmur_key(h.source_address, h.dest_address, {h.dest_port, h.source_port});
			// Clamp the path count into 1..MAX_PATHS and the hop inputs present
			ways = 32'(h.path_count);
			if (ways == 0) ways = 1;
			if (ways > MAX_PATHS) ways = MAX_PATHS;
			if (ways > efhps_pkg::HOP_INPUTS) ways = efhps_pkg::HOP_INPUTS;
			r = '0;
			r.flow_hash = hash;
			if (h.protocol == efhps_pkg::PROTO_TCP || h.protocol == efhps_pkg::PROTO_UDP ||
					h.protocol == efhps_pkg::PROTO_ACK ||
					h.protocol == efhps_pkg::PROTO_NACK) begin
				r.chosen_index = 2'(hash % ways);
				r.chosen_port  = hops[r.chosen_index];
			end else begin
				r.unsupported = 1'b1;
			end
			return r;
		endfunction

		function void note_header(efhps_pkg::flow_in_t h);
			expected_q = {expected_q, select_path(h)};
		endfunction

		function void check_selection(efhps_pkg::flow_out_t got);
			efhps_pkg::flow_out_t want;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected selection: port %0d index %0d hash %08h unsupported %0b",
						got.chosen_port, got.chosen_index, got.flow_hash, got.unsupported);
				return;
			end
			want = expected_q.pop_front();
			if (got.chosen_port !== want.chosen_port || got.chosen_index !== want.chosen_index ||
					got.flow_hash !== want.flow_hash || got.unsupported !== want.unsupported) begin
				mismatches++;
				if (mismatches <= REPORT_MAX) begin
					$display("selection mismatch: expected port %0d index %0d hash %08h unsup %0b",
						want.chosen_port, want.chosen_index, want.flow_hash, want.unsupported);
					$display("                    actual   port %0d index %0d hash %08h unsup %0b",
						got.chosen_port, got.chosen_index, got.flow_hash, got.unsupported);
				end
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	efhps_pkg::flow_in_t  in_data   = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	efhps_pkg::flow_out_t out_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [31:0]          cfg_data  = '0;

	path_select_board board;
	int  cycle_count = 0;
	bit  in_idle_on  = 1'b1;
	bit  out_idle_on = 1'b1;

	ecmp_flow_hash_path_select #(
		.MAX_PATHS(MAX_PATHS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Stop a hung run
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("ecmp_flow_hash_path_select_tb failed");
		$finish;
	end

	function automatic efhps_pkg::flow_in_t make_header(bit [31:0] sa, bit [31:0] da,
			bit [7:0] proto, bit [15:0] sp, bit [15:0] dp, bit [2:0] cnt, bit [31:0] hops);
		efhps_pkg::flow_in_t h;
		h.source_address = sa;
		h.dest_address   = da;
		h.protocol       = proto;
		h.source_port    = sp;
		h.dest_port      = dp;
		h.path_count     = cnt;
		{h.hop_port_3, h.hop_port_2, h.hop_port_1, h.hop_port_0} = hops;
		return h;
	endfunction

	// Mostly supported protocols and in-range path counts, some noise
	function automatic efhps_pkg::flow_in_t random_header();
		efhps_pkg::flow_in_t h;
		int                  pick;
		h.source_address = $urandom;
		h.dest_address   = $urandom;
		h.source_port    = 16'($urandom_range(0, 65535));
		h.dest_port      = 16'($urandom_range(0, 65535));
		{h.hop_port_3, h.hop_port_2, h.hop_port_1, h.hop_port_0} = $urandom;
		pick = $urandom_range(0, 19);
		if (pick == 0) h.source_address = '1;
		if (pick == 1) h.dest_address = '0;
		pick = $urandom_range(0, 19);
		case (pick)
			0, 1, 2, 3: h.protocol = efhps_pkg::PROTO_TCP;
			4, 5, 6, 7: h.protocol = efhps_pkg::PROTO_UDP;
			8, 9, 10, 11: h.protocol = efhps_pkg::PROTO_ACK;
			12, 13, 14, 15, 16: h.protocol = efhps_pkg::PROTO_NACK;
			default: h.protocol = 8'($urandom_range(0, 255));
		endcase
		if ($urandom_range(0, 4) != 0) h.path_count = 3'($urandom_range(1, 4));
		else h.path_count = 3'($urandom_range(0, 7));
		return h;
	endfunction

	// Present one header after a random gap; hold valid across back-to-back transfers
	task automatic send_header(efhps_pkg::flow_in_t h);
		int gap;
		gap = in_idle_on ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= h;
		do @(posedge clk); while (!in_ready);
		board.note_header(h);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
	endtask

	task automatic write_seed(bit [31:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		board.seed = value;
	endtask

	// Result side: random ready stalls, check every transfer
	initial begin
		int stall;
		int taken;
		taken = 0;
		wait (arst_n === 1'b1);
		forever begin
			if (taken % 40 == 0) out_idle_on = $urandom_range(0, 3) != 0;
			stall = out_idle_on ? $urandom_range(0, 8) : 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			board.check_selection(out_data);
			taken++;
		end
	end

	// Header side: directed cases, then random phases under several seeds
	initial begin
		efhps_pkg::flow_in_t directed_q[$];
		bit [31:0]           seeds [PHASES];
		int                  p;
		int                  n;
		board = new;
		board.seed = '0;
		seeds = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, $urandom, $urandom, 32'h0000_0001};

		// Field extremes, every protocol, clamped path counts, unsupported codes
		directed_q = {directed_q, make_header('0, '0, efhps_pkg::PROTO_TCP, '0, '0, 3'd1, '0)};
		directed_q = {directed_q, make_header('1, '1, efhps_pkg::PROTO_UDP, '1, '1, 3'd4, '1)};
		directed_q = {directed_q, make_header(32'h0A00_0001, 32'h0A00_0002,
			efhps_pkg::PROTO_ACK, 16'd1234, 16'd80, 3'd2, 32'h0403_0201)};
		directed_q = {directed_q, make_header(32'hC0A8_0101, 32'h0808_0808,
			efhps_pkg::PROTO_NACK, 16'hFFFF, 16'h0000, 3'd3, 32'h8040_2010)};
		directed_q = {directed_q, make_header(32'hAAAA_AAAA, 32'h5555_5555,
			efhps_pkg::PROTO_TCP, 16'hAAAA, 16'h5555, 3'd4, 32'hAA55_AA55)};
		directed_q = {directed_q, make_header(32'h5555_5555, 32'hAAAA_AAAA,
			efhps_pkg::PROTO_UDP, 16'h5555, 16'hAAAA, 3'd4, 32'h55AA_55AA)};
		directed_q = {directed_q, make_header(32'h1234_5678, 32'h9ABC_DEF0,
			efhps_pkg::PROTO_TCP, 16'd443, 16'd5001, 3'd0, 32'h0D0C_0B0A)};
		directed_q = {directed_q, make_header(32'h1234_5678, 32'h9ABC_DEF0,
			efhps_pkg::PROTO_UDP, 16'd443, 16'd5001, 3'd5, 32'h0D0C_0B0A)};
		directed_q = {directed_q, make_header(32'h8765_4321, 32'h0FED_CBA9,
			efhps_pkg::PROTO_ACK, 16'd7, 16'd9, 3'd6, 32'hF1F2_F3F4)};
		directed_q = {directed_q, make_header(32'hFFFF_0000, 32'h0000_FFFF,
			efhps_pkg::PROTO_NACK, 16'd0, 16'hFFFF, 3'd7, 32'h1122_3344)};
		directed_q = {directed_q, make_header(32'h1234_5678, 32'h9ABC_DEF0, 8'h00, 16'd443,
			16'd5001, 3'd4, 32'h0D0C_0B0A)};
		directed_q = {directed_q, make_header('1, '1, 8'hFF, '1, '1, 3'd7, '1)};
		directed_q = {directed_q, make_header(32'h0102_0304, 32'h0506_0708, 8'h07, 16'd1,
			16'd2, 3'd2, 32'h0908_0706)};
		directed_q = {directed_q, make_header(32'h0102_0304, 32'h0506_0708, 8'hFE, 16'd1,
			16'd2, 3'd0, 32'h0908_0706)};
		directed_q = {directed_q, make_header(32'h0102_0304, 32'h0506_0708, 8'h10, 16'd1,
			16'd2, 3'd3, 32'h0908_0706)};
		directed_q = {directed_q, make_header(32'h8000_0000, 32'h0000_0001,
			efhps_pkg::PROTO_TCP, 16'h8000, 16'h0001, 3'd1, 32'hFF00_FF00)};
		directed_q = {directed_q, make_header(32'h0000_0001, 32'h8000_0000,
			efhps_pkg::PROTO_UDP, 16'h0001, 16'h8000, 3'd3, 32'h00FF_00FF)};
		directed_q = {directed_q, make_header('0, '0, efhps_pkg::PROTO_ACK, '0, '0, 3'd2, '1)};
		directed_q = {directed_q, make_header('1, '0, efhps_pkg::PROTO_NACK, '1, '0, 3'd4,
			32'h8001_7F02)};

		// Reset held, then released on a clock edge
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_q[i]) send_header(directed_q[i]);

		for (p = 0; p < PHASES; p++) begin
			// Phase zero runs on the reset seed
			if (p > 0) begin
				wait_drained();
				write_seed(seeds[p]);
			end
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 40 == 0) in_idle_on = $urandom_range(0, 3) != 0;
				send_header(random_header());
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.mismatches == 0 && board.pending() == 0) begin
			$display("ecmp_flow_hash_path_select_tb passed");
		end else begin
			$display("ecmp_flow_hash_path_select_tb failed");
		end
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/efhps_pkg.sv
hw/rtl/efhps_key_mix.sv
hw/rtl/efhps_hash_fin.sv
hw/rtl/efhps_path_sel.sv
hw/rtl/ecmp_flow_hash_path_select.sv
bench/ecmp_flow_hash_path_select_tb.sv
